### src/source_byte_lexer_macros.svh
// Assertion helpers for the source byte lexer.
`ifndef SOURCE_BYTE_LEXER_MACROS_SVH
`define SOURCE_BYTE_LEXER_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define SBL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define SBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sbl_pkg.sv
package sbl_pkg;

    // Width of the byte offset counter and of stored identifier starts
    localparam int POSITION_WIDTH = 32;

    // Undecided prefix storage and the match window (prefix plus new byte)
    localparam int PEND_DEPTH = 5;
    localparam int WIN_LEN    = PEND_DEPTH + 1;
    localparam int N_ENTRIES  = 32;
    localparam int MAX_RES    = 3;

    localparam logic [5:0] KIND_LITERAL = 6'd30;
    localparam logic [5:0] KIND_IDENT   = 6'd31;
    localparam logic [5:0] KIND_END     = 6'd32;
    localparam logic [5:0] KIND_ERROR   = 6'd33;

    typedef logic [POSITION_WIDTH-1:0] t_pos;

    // Window bytes are left aligned: byte 0 sits in the top eight bits
    typedef logic [8*WIN_LEN-1:0] t_window;

    typedef struct packed {
        logic [8*WIN_LEN-1:0] text;
        logic [2:0]           len;
        logic [5:0]           kind;
    } t_entry;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] indent;
        logic [63:0] literal;
        logic [31:0] start;
        logic [31:0] length;
    } t_token;

    typedef struct packed {
        t_token [MAX_RES-1:0] tok;
        logic [1:0]           cnt;
    } t_step_res;

    // hit: an entry matches in full; open: still undecided; neither: no entry
    typedef struct packed {
        logic       hit;
        logic       open;
        logic [4:0] entry;
    } t_decide;

    // Operators and keywords in match priority order
    localparam t_entry ENTRIES [N_ENTRIES] = '{
        '{{".", 40'd0},     3'd1, 6'd0},
        '{{":", 40'd0},     3'd1, 6'd1},
        '{{"+=", 32'd0},    3'd2, 6'd2},
        '{{"-=", 32'd0},    3'd2, 6'd3},
        '{{"*=", 32'd0},    3'd2, 6'd4},
        '{{"/=", 32'd0},    3'd2, 6'd5},
        '{{"!=", 32'd0},    3'd2, 6'd6},
        '{{"==", 32'd0},    3'd2, 6'd7},
        '{{"<=", 32'd0},    3'd2, 6'd8},
        '{{">=", 32'd0},    3'd2, 6'd9},
        '{{"<", 40'd0},     3'd1, 6'd10},
        '{{">", 40'd0},     3'd1, 6'd11},
        '{{"=", 40'd0},     3'd1, 6'd12},
        '{{"+", 40'd0},     3'd1, 6'd13},
        '{{"-", 40'd0},     3'd1, 6'd14},
        '{{"*", 40'd0},     3'd1, 6'd15},
        '{{"/", 40'd0},     3'd1, 6'd16},
        '{{"%", 40'd0},     3'd1, 6'd17},
        '{{"(", 40'd0},     3'd1, 6'd18},
        '{{")", 40'd0},     3'd1, 6'd19},
        '{{",", 40'd0},     3'd1, 6'd20},
        '{{"if", 32'd0},    3'd2, 6'd21},
        '{{"elif", 16'd0},  3'd4, 6'd22},
        '{{"else", 16'd0},  3'd4, 6'd23},
        '{{"while", 8'd0},  3'd5, 6'd24},
        '{{"func", 16'd0},  3'd4, 6'd25},
        '{"return",         3'd6, 6'd26},
        '{{"and", 24'd0},   3'd3, 6'd27},
        '{{"&&", 32'd0},    3'd2, 6'd27},
        '{{"or", 32'd0},    3'd2, 6'd28},
        '{{"||", 32'd0},    3'd2, 6'd28},
        '{{"int", 24'd0},   3'd3, 6'd29}
    };

    // Match the first n window bytes against the entries as plain prefixes
    function automatic t_decide decide(input t_window w, input logic [2:0] n,
                                       input logic fin);
        t_decide              d;
        logic [N_ENTRIES-1:0] compat;
        logic                 found;
        d      = '0;
        found  = 1'b0;
        compat = '1;
        for (int e = 0; e < N_ENTRIES; e++) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                if ((3'(i) < ENTRIES[e].len) && (3'(i) < n) &&
                    (w[8*(WIN_LEN-1-i) +: 8] != ENTRIES[e].text[8*(WIN_LEN-1-i) +: 8])) begin
                    compat[e] = 1'b0;
                end
            end
        end
        // Take the first compatible entry; a partial one blocks unless at end
        for (int e = 0; e < N_ENTRIES; e++) begin
            if (!found && compat[e]) begin
                if (ENTRIES[e].len <= n) begin
                    d.hit   = 1'b1;
                    d.entry = 5'(e);
                    found   = 1'b1;
                end else if (!fin) begin
                    d.open = 1'b1;
                    found  = 1'b1;
                end
            end
        end
        return d;
    endfunction

endpackage

### src/sbl_step.sv
module sbl_step
    import sbl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_fin,
    output t_step_res  o_res
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    logic [8*PEND_DEPTH-1:0] r_pend,       n_pend;
    logic [2:0]              r_pend_cnt,   n_pend_cnt;
    logic [1:0]              r_mode,       n_mode;
    logic [63:0]             r_accum,      n_accum;
    t_pos                    r_word_start, n_word_start;
    logic [31:0]             r_word_len,   n_word_len;
    t_pos                    r_pos,        n_pos;
    logic [15:0]             r_indent,     n_indent;
    logic                    r_line_start, n_line_start;
    logic                    r_err,        n_err;

    t_window    w_win;
    t_decide    w_d1;
    t_decide    w_d2;
    logic       w_used;
    logic [3:0] w_digit;
    t_pos       w_base;
    t_token     w_cand [4];
    logic [3:0] w_cand_v;
    logic [2:0] w_fill;
    t_step_res  w_res;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [31:0] low_word(input t_pos p);
        logic [63:0] x;
        x = 64'(p);
        return x[31:0];
    endfunction

    function automatic t_token make_tok(input logic [5:0] kind, input logic [15:0] indent,
                                        input logic [63:0] lit, input logic [31:0] start,
                                        input logic [31:0] length);
        t_token t;
        t.kind    = kind;
        t.indent  = indent;
        t.literal = lit;
        t.start   = start;
        t.length  = length;
        return t;
    endfunction

    // Work one byte against the held lexer state
    always_comb begin
        n_pend       = '0;
        n_pend_cnt   = 3'd0;
        n_mode       = r_mode;
        n_accum      = r_accum;
        n_word_start = r_word_start;
        n_word_len   = r_word_len;
        n_pos        = r_pos;
        n_indent     = r_indent;
        n_line_start = r_line_start;
        n_err        = r_err;
        w_used       = 1'b0;
        w_d1         = '0;
        w_d2         = '0;
        w_cand_v     = 4'd0;
        for (int j = 0; j < 4; j++) begin
            w_cand[j] = '0;
        end
        w_digit = 4'(i_byte - "0");
        w_base  = r_pos - t_pos'(r_pend_cnt);

        // Append the new byte after the held prefix
        w_win = {r_pend, 8'h00};
        for (int i = 0; i < WIN_LEN; i++) begin
            if (3'(i) == r_pend_cnt) begin
                w_win[8*(WIN_LEN-1-i) +: 8] = i_byte;
            end
        end

        if (!r_err) begin
            // First pass: finish the run or prefix in progress
            case (r_mode)
                MODE_WORD: begin
                    if (is_alpha(i_byte) || is_digit(i_byte)) begin
                        if (r_word_len != '1) begin
                            n_word_len = r_word_len + 32'd1;
                        end
                        w_used = 1'b1;
                    end else begin
                        w_cand_v[0] = 1'b1;
                        w_cand[0]   = make_tok(KIND_IDENT, r_indent, 64'd0,
                                               low_word(r_word_start), r_word_len);
                        n_mode      = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(i_byte)) begin
                        n_accum = {r_accum[60:0], 3'b000} + {r_accum[62:0], 1'b0}
                                + 64'(w_digit);
                        w_used  = 1'b1;
                    end else begin
                        w_cand_v[0] = 1'b1;
                        w_cand[0]   = make_tok(KIND_LITERAL, r_indent, r_accum, 32'd0, 32'd0);
                        n_mode      = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                    if (r_pend_cnt != 3'd0) begin
                        w_d1 = decide(w_win, r_pend_cnt + 3'd1, i_fin);
                        if (w_d1.hit) begin
                            w_cand_v[0] = 1'b1;
                            w_cand[0]   = make_tok(ENTRIES[w_d1.entry].kind, r_indent,
                                                   64'd0, 32'd0, 32'd0);
                            w_used      = (ENTRIES[w_d1.entry].len == r_pend_cnt + 3'd1);
                        end else if (w_d1.open) begin
                            n_pend     = w_win[8*WIN_LEN-1 -: 8*PEND_DEPTH];
                            n_pend_cnt = r_pend_cnt + 3'd1;
                            w_used     = 1'b1;
                        end else if (is_alpha(r_pend[8*PEND_DEPTH-1 -: 8])) begin
                            // Failed keyword prefix turns into an identifier
                            if (is_alpha(i_byte) || is_digit(i_byte)) begin
                                n_mode       = MODE_WORD;
                                n_word_start = w_base;
                                n_word_len   = 32'(r_pend_cnt) + 32'd1;
                                w_used       = 1'b1;
                            end else begin
                                w_cand_v[0] = 1'b1;
                                w_cand[0]   = make_tok(KIND_IDENT, r_indent, 64'd0,
                                                       low_word(w_base), 32'(r_pend_cnt));
                            end
                        end else begin
                            // Lone operator prefix with no single form: emit an error token and drop the byte
                            w_cand_v[0] = 1'b1;
                            w_cand[0]   = make_tok(KIND_ERROR, r_indent, 64'd0, 32'd0, 32'd0);
                            n_err       = 1'b1;
                            w_used      = 1'b1;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase

            // Second pass: the new byte on its own from idle
            if (!w_used && !n_err) begin
                if (is_space(i_byte)) begin
                    if (i_byte == 8'h0a) begin
                        n_line_start = 1'b1;
                        n_indent     = 16'd0;
                    end else if (r_line_start && (r_indent != '1)) begin
                        n_indent = r_indent + 16'd1;
                    end
                end else begin
                    n_line_start = 1'b0;
                    w_d2 = decide({i_byte, {(8*(WIN_LEN-1)){1'b0}}}, 3'd1, i_fin);
                    if (w_d2.hit) begin
                        w_cand_v[1] = 1'b1;
                        w_cand[1]   = make_tok(ENTRIES[w_d2.entry].kind, r_indent,
                                               64'd0, 32'd0, 32'd0);
                    end else if (w_d2.open) begin
                        n_pend     = {i_byte, {(8*(PEND_DEPTH-1)){1'b0}}};
                        n_pend_cnt = 3'd1;
                    end else if (is_alpha(i_byte)) begin
                        n_mode       = MODE_WORD;
                        n_word_start = r_pos;
                        n_word_len   = 32'd1;
                    end else if (is_digit(i_byte)) begin
                        n_mode  = MODE_NUMBER;
                        n_accum = 64'(w_digit);
                    end else begin
                        w_cand_v[1] = 1'b1;
                        w_cand[1]   = make_tok(KIND_ERROR, r_indent, 64'd0, 32'd0, 32'd0);
                        n_err       = 1'b1;
                    end
                end
            end

            n_pos = r_pos + t_pos'(1);

            // Flush the open run on the last byte
            if (i_fin && !n_err) begin
                if (n_mode == MODE_WORD) begin
                    w_cand_v[2] = 1'b1;
                    w_cand[2]   = make_tok(KIND_IDENT, n_indent, 64'd0,
                                           low_word(n_word_start), n_word_len);
                end else if (n_mode == MODE_NUMBER) begin
                    w_cand_v[2] = 1'b1;
                    w_cand[2]   = make_tok(KIND_LITERAL, n_indent, n_accum, 32'd0, 32'd0);
                end
            end
        end

        // Close the text and return to the reset state
        if (i_fin) begin
            w_cand_v[3]  = 1'b1;
            w_cand[3]    = make_tok(KIND_END, n_indent, 64'd0, 32'd0, 32'd0);
            n_pend       = '0;
            n_pend_cnt   = 3'd0;
            n_mode       = MODE_IDLE;
            n_accum      = 64'd0;
            n_word_start = '0;
            n_word_len   = 32'd0;
            n_pos        = '0;
            n_indent     = 16'd0;
            n_line_start = 1'b1;
            n_err        = 1'b0;
        end

        // Pack the produced tokens in order
        w_res  = '0;
        w_fill = 3'd0;
        for (int j = 0; j < 4; j++) begin
            if (w_cand_v[j] && (w_fill < 3'(MAX_RES))) begin
                w_res.tok[w_fill[1:0]] = w_cand[j];
                w_fill                 = w_fill + 3'd1;
            end
        end
        w_res.cnt = w_fill[1:0];
    end

    assign o_res = w_res;

    // Advance the lexer state on each worked beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= '0;
            r_pend_cnt   <= 3'd0;
            r_mode       <= MODE_IDLE;
            r_accum      <= 64'd0;
            r_word_start <= '0;
            r_word_len   <= 32'd0;
            r_pos        <= '0;
            r_indent     <= 16'd0;
            r_line_start <= 1'b1;
            r_err        <= 1'b0;
        end else if (i_go) begin
            r_pend       <= n_pend;
            r_pend_cnt   <= n_pend_cnt;
            r_mode       <= n_mode;
            r_accum      <= n_accum;
            r_word_start <= n_word_start;
            r_word_len   <= n_word_len;
            r_pos        <= n_pos;
            r_indent     <= n_indent;
            r_line_start <= n_line_start;
            r_err        <= n_err;
        end
    end

endmodule

### src/source_byte_lexer.sv
// channel  dir  handshake          payload
// source   in   i_valid / o_stall  i_source_byte, i_end_of_text
// token    out  o_valid / i_stall  o_token_kind, o_indent_level, o_literal_value,
//                                  o_ident_start, o_ident_length, o_last_of_run
//
// A byte is registered, worked once the result buffer is free, and its tokens go to a
// three-entry result buffer that offers them as token beats. Sustained rate is one byte
// per cycle while the token side does not stall; a byte that yields m > 1 tokens stalls
// the source side while the buffer drains its beats, one per cycle when not stalled.
// Reset is synchronous and clears all lexer state at once; no clearing pass.
// A stalled token beat backs up into o_stall whenever a source byte is waiting,
// even when the buffer holds only the beat being offered.
`include "source_byte_lexer_macros.svh"

module source_byte_lexer
    import sbl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_source_byte,
    input  logic               i_end_of_text,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_token_kind,
    output logic [15:0]        o_indent_level,
    output logic signed [63:0] o_literal_value,
    output logic [31:0]        o_ident_start,
    output logic [31:0]        o_ident_length,
    output logic               o_last_of_run
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_fin;
    t_token [MAX_RES-1:0] r_res;
    logic [1:0]           r_res_cnt;
    logic [1:0]           r_res_head;

    t_step_res w_step;
    t_token    w_head_tok;
    logic      w_out_take;
    logic      w_in_take;
    logic      w_head_last;
    logic      w_buf_free;
    logic      w_proc_go;

    sbl_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_proc_go),
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .o_res   (w_step)
    );

    // Handshake control
    assign w_head_last = (r_res_head + 2'd1 == r_res_cnt);
    assign w_out_take  = o_valid && !i_stall;
    assign w_buf_free  = (r_res_cnt == 2'd0) || (w_out_take && w_head_last);
    assign w_proc_go   = r_in_valid && w_buf_free;
    assign o_stall     = r_in_valid && !w_buf_free;
    assign w_in_take   = i_valid && !o_stall;

    // Hold the source beat until it is worked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_source_byte;
            r_in_fin  <= i_end_of_text;
        end
    end

    // Load tokens of a worked byte, drain one beat per take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt  <= 2'd0;
            r_res_head <= 2'd0;
        end else if (w_proc_go) begin
            r_res_cnt  <= w_step.cnt;
            r_res_head <= 2'd0;
        end else if (w_out_take) begin
            if (w_head_last) begin
                r_res_cnt  <= 2'd0;
                r_res_head <= 2'd0;
            end else begin
                r_res_head <= r_res_head + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc_go) begin
            r_res <= w_step.tok;
        end
    end

    // Drive the token beat from the head slot
    assign w_head_tok      = r_res[r_res_head];
    assign o_valid         = (r_res_cnt != 2'd0);
    assign o_token_kind    = w_head_tok.kind;
    assign o_indent_level  = w_head_tok.indent;
    assign o_literal_value = $signed(w_head_tok.literal);
    assign o_ident_start   = w_head_tok.start;
    assign o_ident_length  = w_head_tok.length;
    assign o_last_of_run   = w_head_last;

    `SBL_ASSERT_NOW(a_head_in_range, i_clk, i_rst_n, (r_res_cnt != 2'd0), (r_res_head < r_res_cnt), "result head beyond filled slots")
    `SBL_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, (w_in_take && r_in_valid), w_proc_go, "source beat taken over an unworked one")
    `SBL_ASSERT_NEXT(a_end_closes, i_clk, i_rst_n, (w_proc_go && r_in_fin), ((r_res_cnt != 2'd0) && (r_res[r_res_cnt - 2'd1].kind == KIND_END)), "last byte did not close with END")

endmodule
